// ===== design/jtps_pkg.sv =====
// Shared types and constants for the Johnson-Trotter permutation stepper.
`timescale 1ns / 1ps
`default_nettype none

package jtps_pkg;

  // Width of one element value and of the size register
  localparam int VAL_W = 4;
  // Number of nibble slots in the permutation result
  localparam int PERM_SLOTS = 12;
  localparam int PERM_W = PERM_SLOTS * VAL_W;
  // Default store depth and size after reset
  localparam int DEF_MAX_ELEMENTS = 12;
  localparam int RESET_SIZE = 12;

  // Command from the sequencer to the element store
  typedef struct packed {
    logic             load;     // reload identity
    logic             latch_n;  // take a new size along with the reload
    logic             swap;     // swap value r with its facing neighbor
    logic [VAL_W-1:0] r;        // value under test or being moved
  } cmd_t;

  // Status from the element store back to the sequencer
  typedef struct packed {
    logic             mobile;   // value r is mobile
    logic [VAL_W-1:0] n;        // active size
  } status_t;

endpackage

`default_nettype wire

// ===== design/jtps_store.sv =====
// Element store: value and position tables, directions, sign and the shared mobility unit.
`timescale 1ns / 1ps
`default_nettype none

module jtps_store #(
  parameter int MAX_ELEMENTS = jtps_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire jtps_pkg::cmd_t              cmd_i,
  input  wire logic [jtps_pkg::VAL_W-1:0]  size_i,
  output jtps_pkg::status_t                status_o,
  output logic [jtps_pkg::PERM_W-1:0]      permutation_o,
  output logic                             odd_parity_o
);
  import jtps_pkg::*;

  localparam int IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [VAL_W-1:0] MaxN = VAL_W'(MAX_ELEMENTS);
  localparam logic [VAL_W-1:0] ResetN =
    (RESET_SIZE > MAX_ELEMENTS) ? VAL_W'(MAX_ELEMENTS) : VAL_W'(RESET_SIZE);
  localparam logic [VAL_W-1:0] MinN = VAL_W'(2);

  logic [VAL_W-1:0]        vap_q [MAX_ELEMENTS];
  logic [IdxW-1:0]         pov_q [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] dir_q;
  logic                    sign_q;
  logic [VAL_W-1:0]        n_q;

  logic [VAL_W-1:0]        r_m1;
  logic [IdxW-1:0]         r_idx;
  logic [IdxW-1:0]         pos;
  logic [VAL_W-1:0]        pos_ext;
  logic [VAL_W-1:0]        nb;
  logic                    nb_ok;
  logic [IdxW-1:0]         nb_idx;
  logic [VAL_W-1:0]        nb_val;
  logic [VAL_W-1:0]        nb_m1;
  logic [IdxW-1:0]         nb_val_idx;
  logic [MAX_ELEMENTS-1:0] flip_mask;
  logic [VAL_W-1:0]        size_clamped;

  // Shared mobility unit: position of r, its facing neighbor, compare
  always_comb begin
    r_m1    = cmd_i.r - VAL_W'(1);
    r_idx   = r_m1[IdxW-1:0];
    pos     = pov_q[r_idx];
    pos_ext = VAL_W'(pos);
    if (dir_q[r_idx]) begin
      nb    = pos_ext + VAL_W'(1);
      nb_ok = (nb < n_q);
    end else begin
      nb    = pos_ext - VAL_W'(1);
      nb_ok = (pos_ext != '0) && (pos_ext < n_q);
    end
    nb_idx     = nb_ok ? nb[IdxW-1:0] : '0;
    nb_val     = vap_q[nb_idx];
    nb_m1      = nb_val - VAL_W'(1);
    nb_val_idx = nb_m1[IdxW-1:0];
  end

  assign status_o.mobile = nb_ok && (nb_val < cmd_i.r);
  assign status_o.n      = n_q;

  // Values above r and within the active size turn around
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      flip_mask[i] = (VAL_W'(i + 1) > cmd_i.r) && (VAL_W'(i + 1) <= n_q);
    end
  end

  // Size saturates into 2..MAX_ELEMENTS when latched
  always_comb begin
    if (size_i < MinN) begin
      size_clamped = MinN;
    end else if (size_i > MaxN) begin
      size_clamped = MaxN;
    end else begin
      size_clamped = size_i;
    end
  end

  // Table and sign update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        vap_q[i] <= VAL_W'(i + 1);
        pov_q[i] <= IdxW'(i);
      end
      dir_q  <= '0;
      sign_q <= 1'b0;
      n_q    <= ResetN;
    end else if (cmd_i.load) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        vap_q[i] <= VAL_W'(i + 1);
        pov_q[i] <= IdxW'(i);
      end
      dir_q  <= '0;
      sign_q <= 1'b0;
      if (cmd_i.latch_n) begin
        n_q <= size_clamped;
      end
    end else if (cmd_i.swap) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        if (IdxW'(i) == nb_idx) begin
          vap_q[i] <= cmd_i.r;
        end
        if (IdxW'(i) == pos) begin
          vap_q[i] <= nb_val;
        end
        if (IdxW'(i) == r_idx) begin
          pov_q[i] <= nb_idx;
        end
        if (IdxW'(i) == nb_val_idx) begin
          pov_q[i] <= pos;
        end
      end
      dir_q  <= dir_q ^ flip_mask;
      sign_q <= ~sign_q;
    end
  end

  // Pack visible positions, zero past the active size
  for (genvar g = 0; g < PERM_SLOTS; g++) begin : g_pack
    if (g < MAX_ELEMENTS) begin : g_slot
      assign permutation_o[g*VAL_W +: VAL_W] = (VAL_W'(g) < n_q) ? vap_q[g] : '0;
    end else begin : g_empty
      assign permutation_o[g*VAL_W +: VAL_W] = '0;
    end
  end

  assign odd_parity_o = sign_q;

  a_load_clears_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !sign_q)
    else $error("sign not cleared by identity reload");

  a_swap_flips_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.swap && !cmd_i.load) |=> (sign_q != $past(sign_q)))
    else $error("swap did not flip sign");

  a_size_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q >= MinN) && (n_q <= MaxN))
    else $error("active size out of range");

endmodule

`default_nettype wire

// ===== design/jtps_seq.sv =====
// Sequencer: scans for the largest mobile value, swaps, rescans and reports the item; a restart reloads instead.
`timescale 1ns / 1ps
`default_nettype none

module jtps_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic                        restart_i,
  output logic                             busy,
  input  wire jtps_pkg::status_t           status_i,
  output jtps_pkg::cmd_t                   cmd_o,
  output logic                             done_o,
  output logic [jtps_pkg::VAL_W-1:0]       moved_value_o,
  output logic                             wrapped_o
);
  import jtps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [VAL_W-1:0] r_q, r_d;
  logic [VAL_W-1:0] moved_q, moved_d;
  logic             wrap_q, wrap_d;
  logic             last_r;

  assign last_r = (r_q == VAL_W'(1));

  // Next state and store commands
  always_comb begin
    state_d       = state_q;
    r_d           = r_q;
    moved_d       = moved_q;
    wrap_d        = wrap_q;
    cmd_o.load    = 1'b0;
    cmd_o.latch_n = 1'b0;
    cmd_o.swap    = 1'b0;
    cmd_o.r       = r_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          moved_d = '0;
          wrap_d  = 1'b0;
          if (restart_i) begin
            cmd_o.load    = 1'b1;
            cmd_o.latch_n = 1'b1;
            state_d       = ST_DONE;
          end else begin
            r_d     = status_i.n;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.mobile) begin
          state_d = ST_SWAP;
        end else if (last_r) begin
          cmd_o.load = 1'b1;
          wrap_d     = 1'b1;
          state_d    = ST_DONE;
        end else begin
          r_d = r_q - VAL_W'(1);
        end
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        moved_d    = r_q;
        r_d        = status_i.n;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.mobile) begin
          state_d = ST_DONE;
        end else if (last_r) begin
          cmd_o.load = 1'b1;
          wrap_d     = 1'b1;
          state_d    = ST_DONE;
        end else begin
          r_d = r_q - VAL_W'(1);
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= VAL_W'(1);
      moved_q <= '0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      moved_q <= moved_d;
      wrap_q  <= wrap_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign moved_value_o = moved_q;
  assign wrapped_o     = wrap_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_swap_after_mobile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP) |-> $past(status_i.mobile))
    else $error("swap without a mobile value");

  a_scan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_CHECK) |-> (r_q != '0))
    else $error("scan index reached zero");

endmodule

`default_nettype wire

// ===== design/johnson_trotter_permutation_step.sv =====
// Top level of the Johnson-Trotter permutation stepper.
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------------
//  item in   start, busy                 restart_i
//  result    done_o (one-cycle strobe)   permutation_o, odd_parity_o, moved_value_o,
//                                        wrapped_o
//  config    cfg_valid_i, cfg_ready_o    cfg_perm_size_i
//
// A restart item reloads the identity and goes straight to its result. An advance scans
// with the shared mobility unit, which tests one value per cycle, down from n to find the
// value to move (value 1 is never mobile), swaps, then scans down from n again to detect
// the end of the sequence, and then gives its result.
// busy is high from the cycle after start is taken through the done_o cycle.
// Reset loads the identity at size 12, saturated to MAX_ELEMENTS; no clearing pass.
// Results cannot be stalled; config is always ready and applies at the next restart.
`timescale 1ns / 1ps
`default_nettype none

module johnson_trotter_permutation_step #(
  parameter int MAX_ELEMENTS = jtps_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        restart_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [jtps_pkg::VAL_W-1:0]  cfg_perm_size_i,
  output logic                             done_o,
  output logic [jtps_pkg::PERM_W-1:0]      permutation_o,
  output logic                             odd_parity_o,
  output logic [jtps_pkg::VAL_W-1:0]       moved_value_o,
  output logic                             wrapped_o
);
  import jtps_pkg::*;

  logic [VAL_W-1:0] perm_size_q;
  cmd_t             cmd;
  status_t          status;

  // Size register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_size_q <= VAL_W'(RESET_SIZE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      perm_size_q <= cfg_perm_size_i;
    end
  end

  jtps_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .restart_i     (restart_i),
    .busy          (busy),
    .status_i      (status),
    .cmd_o         (cmd),
    .done_o        (done_o),
    .moved_value_o (moved_value_o),
    .wrapped_o     (wrapped_o)
  );

  jtps_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .size_i        (perm_size_q),
    .status_o      (status),
    .permutation_o (permutation_o),
    .odd_parity_o  (odd_parity_o)
  );

endmodule

`default_nettype wire

// ===== verif/johnson_trotter_permutation_step_tb.sv =====
// Self-checking testbench for the Johnson-Trotter permutation stepper.
`timescale 1ns / 1ps

module johnson_trotter_permutation_step_tb;
  import jtps_pkg::*;

  localparam int MAX_N = DEF_MAX_ELEMENTS;
  localparam int DRAIN_CYCLES = 2 * MAX_N + 16;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_RESTART = 1'b1
  } step_op_e;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic              odd;
    logic [VAL_W-1:0]  moved;
    logic              wrap;
  } perm_result_t;

  // One directed row: either a size write or an item, optionally with a typed-in result
  typedef struct packed {
    row_kind_e         kind;
    logic [VAL_W-1:0]  size_val;
    step_op_e          op;
    logic              typed;
    perm_result_t      want;
  } plan_row_t;

  localparam logic [PERM_W-1:0] ID12 = 48'hCBA987654321;
  localparam int PLAN_LEN = 29;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{ID12, 1'b0, 4'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b1, '{48'hBCA987654321, 1'b1, 4'd12, 1'b0}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{ID12, 1'b0, 4'd0, 1'b0}},
    // size below range saturates to 2; every advance at n=2 wraps
    '{ROW_CFG,  4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{48'h21, 1'b0, 4'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b1, '{48'h21, 1'b0, 4'd2, 1'b1}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b1, '{48'h21, 1'b0, 4'd2, 1'b1}},
    '{ROW_CFG,  4'd1,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{48'h21, 1'b0, 4'd0, 1'b0}},
    // size above range saturates to the store depth
    '{ROW_CFG,  4'd15, OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{ID12, 1'b0, 4'd0, 1'b0}},
    // full n=3 sequence, including its wrap
    '{ROW_CFG,  4'd3,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{48'h321, 1'b0, 4'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    // new size must not apply before the next restart
    '{ROW_CFG,  4'd12, OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{ID12, 1'b0, 4'd0, 1'b0}},
    '{ROW_CFG,  4'd14, OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0},
    '{ROW_ITEM, 4'd0,  OP_RESTART, 1'b1, '{ID12, 1'b0, 4'd0, 1'b0}},
    '{ROW_ITEM, 4'd0,  OP_ADVANCE, 1'b0, '0}
  };

  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 222;
  int idle_pct [PHASES] = '{0, 60, 8, 0, 60, 8, 0, 8};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              restart_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [VAL_W-1:0]  cfg_perm_size_i = '0;
  logic              done_o;
  logic [PERM_W-1:0] permutation_o;
  logic              odd_parity_o;
  logic [VAL_W-1:0]  moved_value_o;
  logic              wrapped_o;

  johnson_trotter_permutation_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .restart_i      (restart_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_perm_size_i(cfg_perm_size_i),
    .done_o         (done_o),
    .permutation_o  (permutation_o),
    .odd_parity_o   (odd_parity_o),
    .moved_value_o  (moved_value_o),
    .wrapped_o      (wrapped_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the element store
  logic [VAL_W-1:0] perm_at [MAX_N];
  logic [VAL_W-1:0] slot_of [MAX_N];
  logic             heads_right [MAX_N];
  logic             sign_bit;
  logic [VAL_W-1:0] size_setting;
  int               live_size;

  perm_result_t expected_perms [$];
  int           fault_count = 0;

  function automatic void load_identity();
    for (int i = 0; i < MAX_N; i++) begin
      perm_at[i] = VAL_W'(i + 1);
      slot_of[i] = VAL_W'(i);
      heads_right[i] = 1'b0;
    end
    sign_bit = 1'b0;
  endfunction

  // Largest value whose facing neighbor exists and is smaller, 0 if none
  function automatic int largest_mobile_value();
    int p;
    int nb;
    for (int r = live_size; r > 0; r--) begin
      p = int'(slot_of[r-1]);
      if (heads_right[r-1]) begin
        if (p + 1 >= live_size) continue;
        nb = p + 1;
      end else begin
        if (p == 0 || p >= live_size) continue;
        nb = p - 1;
      end
      if (int'(perm_at[nb]) < r) return r;
    end
    return 0;
  endfunction

  function automatic perm_result_t next_permutation(step_op_e op);
    perm_result_t res;
    int r;
    int rp;
    int lp;
    int lv;
    res = '0;
    if (op == OP_RESTART) begin
      live_size = (size_setting < 2) ? 2 : (size_setting > MAX_N) ? MAX_N : int'(size_setting);
      load_identity();
    end else begin
      r = largest_mobile_value();
      if (r == 0) begin
        load_identity();
        res.wrap = 1'b1;
      end else begin
        rp = int'(slot_of[r-1]);
        lp = heads_right[r-1] ? rp + 1 : rp - 1;
        lv = int'(perm_at[lp]);
        perm_at[lp] = VAL_W'(r);
        perm_at[rp] = VAL_W'(lv);
        slot_of[r-1] = VAL_W'(lp);
        if (lv >= 1 && lv <= MAX_N) slot_of[lv-1] = VAL_W'(rp);
        sign_bit = ~sign_bit;
        for (int v = r + 1; v <= live_size; v++) heads_right[v-1] = ~heads_right[v-1];
        res.moved = VAL_W'(r);
        if (largest_mobile_value() == 0) begin
          load_identity();
          res.wrap = 1'b1;
        end
      end
    end
    for (int i = 0; i < live_size && i < PERM_SLOTS; i++) res.perm[VAL_W*i +: VAL_W] = perm_at[i];
    res.odd = sign_bit;
    return res;
  endfunction

  // Offer one item, optionally after an idle gap, and book its expected result
  task automatic send_item(step_op_e op, int gap_pct, logic typed, perm_result_t typed_res);
    perm_result_t res;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    start <= 1'b1;
    restart_i <= op;
    do @(posedge clk_i); while (busy);
    res = next_permutation(op);
    expected_perms.push_back(typed ? typed_res : res);
  endtask

  // Size write, only once the block has drained
  task automatic write_size(logic [VAL_W-1:0] val);
    start <= 1'b0;
    do @(posedge clk_i); while (expected_perms.size() != 0 || busy);
    cfg_valid_i <= 1'b1;
    cfg_perm_size_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_setting = val;
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    perm_result_t want;
    if (rst_ni && done_o) begin
      if (expected_perms.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result: perm %h", permutation_o);
      end else begin
        want = expected_perms.pop_front();
        if (permutation_o !== want.perm || odd_parity_o !== want.odd ||
            moved_value_o !== want.moved || wrapped_o !== want.wrap) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: perm %h/%h odd %b/%b moved %0d/%0d wrap %b/%b (exp/got)",
                     want.perm, permutation_o, want.odd, odd_parity_o,
                     want.moved, moved_value_o, want.wrap, wrapped_o);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int drain;
    logic [VAL_W-1:0] sz;
    size_setting = VAL_W'(RESET_SIZE);
    live_size = (RESET_SIZE > MAX_N) ? MAX_N : RESET_SIZE;
    load_identity();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_size(plan[i].size_val);
      else send_item(plan[i].op, 0, plan[i].typed, plan[i].want);
    end

    // random phases: mostly small sizes, long advance runs, rare restarts and size writes
    for (int ph = 0; ph < PHASES; ph++) begin
      sz = ($urandom_range(99) < 80) ? VAL_W'($urandom_range(2, 5)) : VAL_W'($urandom_range(0, 15));
      write_size(sz);
      send_item(OP_RESTART, idle_pct[ph], 1'b0, '0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) == 0) begin
          sz = ($urandom_range(99) < 80) ? VAL_W'($urandom_range(2, 5)) : VAL_W'($urandom_range(0, 15));
          write_size(sz);
        end
        send_item(($urandom_range(99) < 4) ? OP_RESTART : OP_ADVANCE, idle_pct[ph], 1'b0, '0);
      end
    end

    // drain and settle
    start <= 1'b0;
    drain = 0;
    while (expected_perms.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && expected_perms.size() == 0) begin
      $display("johnson_trotter_permutation_step_tb: clean");
    end else begin
      if (expected_perms.size() != 0) $display("%0d results never arrived", expected_perms.size());
      $display("johnson_trotter_permutation_step_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("johnson_trotter_permutation_step_tb: errors");
    $finish;
  end

endmodule
